@@ rtl/bch_remainder_encoder_checker_macros.svh @@
// ----------------------------------------------------------------------------
// bch remainder encoder/checker assertion macros
// shared concurrent assertion forms for the encoder rtl
// ----------------------------------------------------------------------------
`ifndef BCH_REMAINDER_ENCODER_CHECKER_MACROS_SVH
`define BCH_REMAINDER_ENCODER_CHECKER_MACROS_SVH

// same-cycle implication, masked during reset
`define BCE_ASSERT_IMPLIES(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define BCE_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bce_pkg.sv @@
// ----------------------------------------------------------------------------
// bce_pkg
// shared types and codes of the bch remainder encoder/checker
// ----------------------------------------------------------------------------
`default_nettype none

package bce_pkg;

  // input beat kinds (tuser of the input channel)
  localparam logic ACT_DATA  = 1'b0;
  localparam logic ACT_CHECK = 1'b1;

  // result beat kinds (tuser of the output channel)
  localparam logic KIND_CHECK_BYTE = 1'b0;
  localparam logic KIND_VERDICT    = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_GENERATOR   = 2'd0;
  localparam logic [1:0] CFG_DEGREE      = 2'd1;
  localparam logic [1:0] CFG_CHECK_LEN   = 2'd2;
  localparam logic [1:0] CFG_VERIFY_MODE = 2'd3;

  // register reset values
  localparam logic [6:0] DEGREE_RST    = 7'd52;
  localparam logic [3:0] CHECK_LEN_RST = 4'd7;

  // most check bytes per chunk
  localparam logic [3:0] ECC_MAX = 4'd8;

  localparam logic [7:0] BYTE_INV = 8'hff;

  // request to load the result serializer
  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [63:0] value;
    logic [3:0]  count;
    logic        match;
  } bce_load_t;

endpackage

`default_nettype wire

@@ rtl/bce_lfsr_byte.sv @@
// ----------------------------------------------------------------------------
// bce_lfsr_byte
// one byte of the reflected remainder update, eight shift steps unrolled
// ----------------------------------------------------------------------------
`default_nettype none

module bce_lfsr_byte #(
  parameter int W = 64
) (
  input  wire logic [W-1:0] rem_in,
  input  wire logic [W-1:0] gen_in,
  input  wire logic [7:0]   byte_in,
  output logic      [W-1:0] rem_out
);
  import bce_pkg::*;

  always_comb begin
    logic [W-1:0] r;
    r = rem_in ^ W'(byte_in ^ BYTE_INV);
    for (int j = 0; j < 8; j++) begin
      if (r[0]) begin
        r = r ^ gen_in;
      end
      r = r >> 1;
    end
    rem_out = r;
  end

endmodule

`default_nettype wire

@@ rtl/bce_emit.sv @@
// ----------------------------------------------------------------------------
// bce_emit
// result serializer: holds one run of check bytes or a verdict and sends it
// ----------------------------------------------------------------------------
`default_nettype none

`include "bch_remainder_encoder_checker_macros.svh"

module bce_emit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire bce_pkg::bce_load_t  load,
  output logic                     load_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_kind,
  output logic [7:0]               out_byte,
  output logic                     out_last,
  output logic                     out_match
);
  import bce_pkg::*;

  logic [3:0]  cnt_r,   cnt_nxt;
  logic [63:0] val_r,   val_nxt;
  logic        kind_r,  kind_nxt;
  logic        match_r, match_nxt;
  logic        fire;

  assign fire       = (cnt_r != 4'd0) && out_ready;
  assign load_ready = (cnt_r == 4'd0) || ((cnt_r == 4'd1) && out_ready);

  always_comb begin
    cnt_nxt   = cnt_r;
    val_nxt   = val_r;
    kind_nxt  = kind_r;
    match_nxt = match_r;
    if (fire) begin
      cnt_nxt = cnt_r - 4'd1;
      val_nxt = val_r >> 8;
    end
    if (load.valid) begin
      cnt_nxt   = load.count;
      val_nxt   = load.value;
      kind_nxt  = load.kind;
      match_nxt = load.match;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 4'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    val_r   <= val_nxt;
    kind_r  <= kind_nxt;
    match_r <= match_nxt;
  end

  assign out_valid = (cnt_r != 4'd0);
  assign out_kind  = kind_r;
  assign out_byte  = (kind_r == KIND_VERDICT) ? 8'h00 : ~val_r[7:0];
  assign out_last  = (cnt_r == 4'd1);
  assign out_match = (kind_r == KIND_VERDICT) ? match_r : 1'b0;

  `BCE_ASSERT_IMPLIES(a_verdict_single, clk, rst_n, out_valid && (kind_r == KIND_VERDICT), cnt_r == 4'd1, "verdict run longer than one beat")
  `BCE_ASSERT_IMPLIES(a_no_load_busy, clk, rst_n, cnt_r > 4'd1, !load_ready, "serializer ready while a run is pending")
  `BCE_ASSERT_IMPLIES(a_count_range, clk, rst_n, 1'b1, cnt_r <= ECC_MAX, "run length above eight beats")
  `BCE_ASSERT_NEXT(a_drain_idle, clk, rst_n, fire && (cnt_r == 4'd1) && !load.valid, !out_valid, "beat after the last of a run without a load")

endmodule

`default_nettype wire

@@ rtl/bch_remainder_encoder_checker.sv @@
// ----------------------------------------------------------------------------
// bch_remainder_encoder_checker
// byte-serial bch check byte generator and checker
// ----------------------------------------------------------------------------
// usage:
//   input beats carry a data byte (tuser low) or a stored check byte
//   (tuser high); tlast marks the final data or check byte
//   each data byte updates the remainder in its accept cycle
//   generate mode: the last data byte loads one beat per check byte, low
//   byte first; the first is visible in the cycle after the input beat
//   verify mode: the last check byte yields one verdict beat (tuser high,
//   tdata bit 8 = pass) in the following cycle
//   throughput: one input beat per cycle, but the input stalls while a run of result beats
//   is pending, until the cycle in which the receiver takes its last beat
//   reset clears the chunk state and the result channel; registers return
//   to generator 0, degree 52, seven check bytes, generate mode; the block
//   does not enforce idle writes, so the user must write configuration only while the block is idle
// ----------------------------------------------------------------------------
`default_nettype none

module bch_remainder_encoder_checker #(
  parameter int POLY_WIDTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_value
  input  wire logic        in_tuser,   // [0] action
  input  wire logic        in_tlast,   // last
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] check_byte, [8] matches_res, rest zero
  output logic             out_tuser,  // [0] result_kind
  output logic             out_tlast   // last_of_run
);
  import bce_pkg::*;

  // configuration registers
  logic [POLY_WIDTH-1:0] gen_r;
  logic [6:0]            degree_r;
  logic [3:0]            ecc_r;
  logic                  verify_r;

  // chunk state
  logic [POLY_WIDTH-1:0] rem_r,    rem_nxt;
  logic [63:0]           stored_r, stored_nxt;
  logic [3:0]            ccount_r, ccount_nxt;

  logic [POLY_WIDTH-1:0] rem_upd;
  logic [63:0]           dmask;
  logic [3:0]            n_eff;
  logic                  in_fire;
  bce_load_t             load;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r    <= '0;
      degree_r <= DEGREE_RST;
      ecc_r    <= CHECK_LEN_RST;
      verify_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GENERATOR:   gen_r    <= cfg_wdata[POLY_WIDTH-1:0];
        CFG_DEGREE:      degree_r <= cfg_wdata[6:0];
        CFG_CHECK_LEN:   ecc_r    <= cfg_wdata[3:0];
        CFG_VERIFY_MODE: verify_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // check lengths above eight behave as eight
  assign n_eff = (ecc_r > ECC_MAX) ? ECC_MAX : ecc_r;

  // bits below degree take part in the compare
  always_comb begin
    for (int i = 0; i < 64; i++) begin
      dmask[i] = (7'(i) < degree_r);
    end
  end

  bce_lfsr_byte #(.W(POLY_WIDTH)) u_lfsr (
    .rem_in  (rem_r),
    .gen_in  (gen_r),
    .byte_in (in_tdata),
    .rem_out (rem_upd)
  );

  assign in_fire = in_tvalid && in_tready;

  always_comb begin
    rem_nxt    = rem_r;
    stored_nxt = stored_r;
    ccount_nxt = ccount_r;
    load       = '0;
    if (in_fire) begin
      if (in_tuser == ACT_DATA) begin
        rem_nxt = rem_upd;
        // generate mode: last data byte emits the check bytes and clears
        if (in_tlast && !verify_r) begin
          rem_nxt    = '0;
          load.valid = (n_eff != 4'd0);
          load.kind  = KIND_CHECK_BYTE;
          load.value = 64'(rem_upd);
          load.count = n_eff;
          load.match = 1'b0;
        end
      end else if (verify_r) begin
        // extra check bytes beyond the check length are dropped
        if (ccount_r < n_eff) begin
          stored_nxt = stored_r | (64'(in_tdata ^ BYTE_INV) << {ccount_r[2:0], 3'b000});
          ccount_nxt = ccount_r + 4'd1;
        end
        if (in_tlast) begin
          load.valid = 1'b1;
          load.kind  = KIND_VERDICT;
          load.value = '0;
          load.count = 4'd1;
          load.match = (64'(rem_r) == (stored_nxt & dmask));
          rem_nxt    = '0;
          stored_nxt = '0;
          ccount_nxt = 4'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r    <= '0;
      stored_r <= '0;
      ccount_r <= 4'd0;
    end else begin
      rem_r    <= rem_nxt;
      stored_r <= stored_nxt;
      ccount_r <= ccount_nxt;
    end
  end

  // result serializer
  logic [7:0] res_byte;
  logic       res_match;

  bce_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .load_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (out_tuser),
    .out_byte   (res_byte),
    .out_last   (out_tlast),
    .out_match  (res_match)
  );

  assign out_tdata = {7'b0, res_match, res_byte};

endmodule

`default_nettype wire

@@ verif/bch_remainder_encoder_checker_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bch_remainder_encoder_checker_tb
// self-checking bench for the byte-serial bch check byte generator/checker.
// a scoreboard class keeps its own copy of the reflected remainder, the
// assembled check value and the registers, predicts every result beat and
// compares it against the result channel. stimulus runs a directed pass over
// the corner cases, then random chunks under random register settings with
// random gaps on both sides, a long receiver hold-off and a full drain.
// ----------------------------------------------------------------------------

module bch_remainder_encoder_checker_tb;
  import bce_pkg::*;

  localparam int POLY_WIDTH   = 64;
  localparam int LATENCY      = 4;     // settle cycles after the last result
  localparam int HOLD_CYCLES  = 150;   // long receiver hold-off
  localparam int RANDOM_ITEMS = 200;

  // one result beat as the bench expects it
  typedef struct packed {
    logic       kind;
    logic [7:0] check_byte;
    logic       last_of_run;
    logic       pass_flag;
  } bch_result_t;

  // --------------------------------------------------------------------------
  // scoreboard: predicts result beats from accepted input beats
  // --------------------------------------------------------------------------
  class bch_result_board;
    logic [63:0] generator;
    logic [6:0]  degree;
    logic [3:0]  chk_len_cfg;
    logic        verify_mode;
    logic [63:0] remainder;
    logic [63:0] stored_check;
    logic [3:0]  check_count;
    bch_result_t expected_results[$];
    int          errors;
    int          check_bytes_seen;
    int          verdicts_pass;
    int          verdicts_fail;

    function new();
      generator        = '0;
      degree           = DEGREE_RST;
      chk_len_cfg      = CHECK_LEN_RST;
      verify_mode      = 1'b0;
      remainder        = '0;
      stored_check     = '0;
      check_count      = '0;
      errors           = 0;
      check_bytes_seen = 0;
      verdicts_pass    = 0;
      verdicts_fail    = 0;
    endfunction

    task report(string what);
      $display("MISMATCH @%0t: %s", $time, what);
      errors++;
    endtask

    function void set_register(logic [1:0] index, logic [63:0] value);
      case (index)
        CFG_GENERATOR:   generator   = value;
        CFG_DEGREE:      degree      = value[6:0];
        CFG_CHECK_LEN:   chk_len_cfg = value[3:0];
        CFG_VERIFY_MODE: verify_mode = value[0];
        default: ;
      endcase
    endfunction

    // check bytes per chunk; anything above the maximum acts as the maximum
    function int unsigned check_len();
      return (chk_len_cfg > ECC_MAX) ? ECC_MAX : chk_len_cfg;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // returns 0 for a beat the block ignores
    function bit note_beat(logic action, logic [7:0] value, logic last);
      logic [63:0] wmask;
      logic [63:0] r;
      logic [63:0] g;
      logic [63:0] dmask;
      int unsigned n;
      int unsigned j;
      wmask = {64{1'b1}} >> (64 - POLY_WIDTH);
      n = check_len();
      if (action == ACT_DATA) begin
        r = (remainder ^ {56'd0, value ^ BYTE_INV}) & wmask;
        g = generator & wmask;
        for (j = 0; j < 8; j++) begin
          if (r[0]) r ^= g;
          r = r >> 1;
        end
        remainder = r & wmask;
        if (last && !verify_mode) begin
          r = remainder;
          for (j = 0; j < n; j++) begin
            expected_results.push_back('{KIND_CHECK_BYTE, r[7:0] ^ BYTE_INV,
                                         (j == n - 1), 1'b0});
            r = r >> 8;
          end
          remainder = '0;
        end
        return 1'b1;
      end
      // check byte in generate mode: no effect at all
      if (!verify_mode) return 1'b0;
      if (check_count < n) begin
        stored_check |= {56'd0, value ^ BYTE_INV} << (8 * check_count);
        check_count++;
      end
      if (last) begin
        dmask = (degree >= 64) ? {64{1'b1}} : ((64'd1 << degree) - 64'd1);
        expected_results.push_back('{KIND_VERDICT, 8'h00, 1'b1,
                                     remainder == (stored_check & dmask)});
        remainder    = '0;
        stored_check = '0;
        check_count  = '0;
      end
      return 1'b1;
    endfunction

    task check_result(logic kind, logic [15:0] data, logic last);
      bch_result_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result beat kind=%0b data=%h last=%0b",
                         kind, data, last));
        return;
      end
      want = expected_results.pop_front();
      if (kind !== want.kind)
        report($sformatf("result_kind %0b, expected %0b", kind, want.kind));
      if (data[7:0] !== want.check_byte)
        report($sformatf("check_byte %h, expected %h", data[7:0], want.check_byte));
      if (data[8] !== want.pass_flag)
        report($sformatf("matches_res %0b, expected %0b", data[8], want.pass_flag));
      if (data[15:9] !== '0)
        report($sformatf("tdata padding %h not zero", data[15:9]));
      if (last !== want.last_of_run)
        report($sformatf("last_of_run %0b, expected %0b", last, want.last_of_run));
      if (want.kind == KIND_VERDICT) begin
        if (want.pass_flag) verdicts_pass++;
        else verdicts_fail++;
      end else begin
        check_bytes_seen++;
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block under test
  // --------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [1:0]  cfg_index  = CFG_GENERATOR;
  logic [63:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = '0;
  logic        in_tuser   = ACT_DATA;
  logic        in_tlast   = 1'b0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bch_remainder_encoder_checker #(
    .POLY_WIDTH(POLY_WIDTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // [7:0] byte_value
    .in_tuser  (in_tuser),    // [0] action
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),   // [7:0] check_byte, [8] matches_res
    .out_tuser (out_tuser),   // [0] result_kind
    .out_tlast (out_tlast)
  );

  bch_result_board board;
  bit sender_steady   = 1'b0;   // no gaps from the sender
  bit receiver_steady = 1'b0;   // no stalls from the receiver
  bit hold_req        = 1'b0;   // asks the receiver for one long hold-off
  int hold_left       = 0;
  int items_sent      = 0;
  int items_ignored   = 0;
  int configs_used    = 0;

  // --------------------------------------------------------------------------
  // receiver: random stalls, plus one long hold-off counted here
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_req && hold_left == 0) hold_left = HOLD_CYCLES;
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
      if (hold_left == 0) hold_req = 1'b0;
    end else begin
      out_tready <= receiver_steady || ($urandom_range(0, 99) >= 15);
    end
  end

  // result monitor: every accepted result beat goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_result(out_tuser, out_tdata, out_tlast);
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("timeout: %0d result beats still expected", board.pending());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // driving tasks
  // --------------------------------------------------------------------------

  // one input beat; an optional random gap first, then hold until accepted
  task automatic send_beat(logic action, logic [7:0] value, logic last);
    int gap;
    if (!sender_steady && $urandom_range(0, 99) < 15) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= action;
    in_tdata  <= value;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    if (board.note_beat(action, value, last)) items_sent++;
    else items_ignored++;
  endtask

  // stop offering, wait for every expected result, then let the block settle
  // (a chunk with zero check bytes leaves no result to wait for)
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (LATENCY) @(posedge clk);
  endtask

  // one register write beat; the caller lowers the write enable
  task automatic write_reg(logic [1:0] index, logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    board.set_register(index, value);
  endtask

  // all four registers; unused upper bits of the narrow ones carry junk
  task automatic configure(logic [63:0] gen, logic [6:0] deg, logic [3:0] ecc,
                           logic verify);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(CFG_GENERATOR, gen);
    write_reg(CFG_DEGREE, {junk[63:7], deg});
    write_reg(CFG_CHECK_LEN, {junk[63:4], ecc});
    write_reg(CFG_VERIFY_MODE, {junk[63:1], verify});
    cfg_we <= 1'b0;
    configs_used++;
  endtask

  // stored check bytes for the current remainder, optionally with one bad bit
  task automatic send_checks(int unsigned count, bit corrupt);
    logic [63:0] rem;
    logic [7:0]  b;
    int unsigned j;
    int unsigned bad_at;
    rem    = board.remainder;
    bad_at = $urandom_range(0, count - 1);
    for (j = 0; j < count; j++) begin
      b = (j < 8) ? rem[8 * j +: 8] ^ BYTE_INV : 8'($urandom);
      if (corrupt && j == bad_at) b ^= 8'h01 << $urandom_range(0, 7);
      send_beat(ACT_CHECK, b, j == count - 1);
    end
  endtask

  // one data chunk with random content; in verify mode the check bytes follow
  task automatic random_chunk();
    int unsigned len;
    int unsigned n;
    int unsigned j;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
    for (j = 0; j < len; j++) begin
      // stray check byte in generate mode, dropped by the block
      if (!board.verify_mode && $urandom_range(0, 9) == 0)
        send_beat(ACT_CHECK, 8'($urandom), 1'($urandom_range(0, 1)));
      send_beat(ACT_DATA, 8'($urandom), j == len - 1);
    end
    if (board.verify_mode) begin
      n = board.check_len();
      if (n == 0) n = 1;
      case ($urandom_range(0, 9))
        7:       send_checks(n + $urandom_range(1, 2), $urandom_range(0, 3) == 0);
        8:       send_checks($urandom_range(1, n), 1'b0);
        9:       ;  // no check bytes: the next chunk keeps building on this one
        default: send_checks(n, $urandom_range(0, 3) == 0);
      endcase
    end
    // occasional noise beats with every field random
    if ($urandom_range(0, 11) == 0)
      repeat ($urandom_range(1, 3))
        send_beat(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // random register setting; passes need the remainder to fit inside degree
  task automatic random_config(bit force_generate);
    logic [63:0] gen;
    logic [63:0] dmask;
    logic [6:0]  deg;
    logic [3:0]  ecc;
    logic        verify;
    int unsigned n;
    verify = force_generate ? 1'b0 : 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       ecc = 4'd0;
      1:       ecc = 4'($urandom_range(9, 15));
      default: ecc = 4'($urandom_range(1, 8));
    endcase
    n = (ecc > ECC_MAX) ? ECC_MAX : ecc;
    case ($urandom_range(0, 9))
      0:       deg = 7'd0;
      1:       deg = 7'd64;
      2:       deg = 7'($urandom_range(65, 127));
      default: deg = 7'($urandom_range(1, (n == 0) ? 8 : 8 * n));
    endcase
    gen   = {$urandom, $urandom};
    dmask = (deg >= 64) ? {64{1'b1}} : ((64'd1 << deg) - 64'd1);
    if (verify && $urandom_range(0, 3) != 0) gen &= dmask;
    configure(gen, deg, ecc, verify);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int phase;
    int random_start;
    board = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // reset settings: generator zero, seven check bytes, generate mode
    send_beat(ACT_DATA, 8'h00, 1'b1);
    send_beat(ACT_CHECK, 8'ha5, 1'b1);      // ignored in generate mode
    send_beat(ACT_DATA, 8'hff, 1'b1);

    // all-ones generator, widest degree, check length above the maximum
    wait_idle();
    configure({64{1'b1}}, 7'd127, 4'd15, 1'b0);
    send_beat(ACT_DATA, 8'h80, 1'b0);
    send_beat(ACT_DATA, 8'h7f, 1'b1);

    // zero check bytes: last data byte emits nothing, remainder still cleared
    wait_idle();
    configure(64'h1, 7'd52, 4'd0, 1'b0);
    send_beat(ACT_DATA, 8'ha5, 1'b1);

    // verify, full 64-bit compare, eight good check bytes
    wait_idle();
    configure(64'hc96c_5795_d787_0f42, 7'd64, ECC_MAX, 1'b1);
    send_beat(ACT_DATA, 8'h3c, 1'b1);       // last data byte in verify: silent
    send_checks(ECC_MAX, 1'b0);

    // short code, extra check bytes beyond the check length are not stored
    wait_idle();
    configure(64'h8408, 7'd16, 4'd2, 1'b1);
    send_beat(ACT_DATA, 8'h01, 1'b0);
    send_beat(ACT_DATA, 8'hfe, 1'b1);
    send_checks(4, 1'b0);

    // degree zero and no check bytes: passes only on a zero remainder
    wait_idle();
    configure(64'h8000_0000_0000_0000, 7'd0, 4'd0, 1'b1);
    send_beat(ACT_DATA, 8'hff, 1'b1);       // remainder stays zero
    send_beat(ACT_CHECK, 8'h00, 1'b1);
    send_beat(ACT_DATA, 8'h00, 1'b1);       // remainder nonzero
    send_beat(ACT_CHECK, 8'hff, 1'b1);

    // ---- random part ----
    random_start = items_sent;
    phase = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      wait_idle();
      random_config(phase == 1);
      // a stretch with no gaps and no stalls on either side
      sender_steady   = (phase == 2);
      receiver_steady = (phase == 2);
      // long receiver hold-off while the sender keeps pushing chunks
      if (phase == 1) hold_req = 1'b1;
      repeat ($urandom_range(4, 8)) begin
        random_chunk();
        // sender pause until the result channel has drained
        if (phase == 3 && $urandom_range(0, 2) == 0) wait_idle();
      end
      phase++;
    end

    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
    wait_idle();

    $display("run covered %0d input beats (%0d ignored) over %0d register settings",
             items_sent, items_ignored, configs_used);
    $display("results checked: %0d check bytes, %0d verdicts passed, %0d failed",
             board.check_bytes_seen, board.verdicts_pass, board.verdicts_fail);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
